>>> rtl/core/ptb_pkg.sv
package ptb_pkg;

  // bank size and derived widths
  localparam int TIMERS = 16;
  localparam int IDX_W  = 4;
  localparam int SLOTS  = (TIMERS < (1 << IDX_W)) ? TIMERS : (1 << IDX_W);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [31:0] FLOOR_RESET = 32'd946684800;
  localparam logic [1:0]  KIND_INVALID = 2'd3;

  typedef logic [31:0]       sec_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    ACT_DEFINE = 3'd0,
    ACT_START  = 3'd1,
    ACT_PAUSE  = 3'd2,
    ACT_RESUME = 3'd3,
    ACT_STOP   = 3'd4,
    ACT_REMOVE = 3'd5,
    ACT_TICK   = 3'd6,
    ACT_QUERY  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    RUN_IDLE  = 2'd0,
    RUN_RUN   = 2'd1,
    RUN_PAUSE = 2'd2,
    RUN_DONE  = 2'd3
  } run_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_BAD_STATE = 2'd2,
    STS_BAD_DEF   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RK_REPLY    = 2'd0,
    RK_EXPIRY   = 2'd1,
    RK_TICK_END = 2'd2
  } rkind_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_CMD  = 2'd1,
    FSM_SCAN = 2'd2,
    FSM_END  = 2'd3
  } fsm_e;

  typedef struct packed {
    logic       tstart;
    logic [7:0] number;
    logic [1:0] kind;
    logic       has_target;
    logic       rep;
  } def_t;

  // one memory word per slot
  typedef struct packed {
    run_e run;
    sec_t start;
    sec_t paused;
    sec_t interval;
    def_t def;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    we;
    status_e status;
    entry_t  entry;
    sec_t    remaining;
    logic    expired;
  } eval_t;

endpackage

>>> rtl/core/pausable_timer_bank_top.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------------------
// command   | in        | start / busy          | action_i .. target_start_i
// result    | out       | result_valid_o strobe | status_code_o .. last_o
// config    | in        | cfg_we_i              | cfg_wdata_i (clock valid floor)
//
// a command item reads its slot word from memory on acceptance, then in the command
// state modifies it, writes it back and registers its reply; busy is high in that state
// a tick item reads the slots one per cycle in index order, then gives its tick end;
// a tick at or below the floor scans nothing and gives its tick end at once
// reset clears the used bits and the sequencer and sets the floor to FLOOR_RESET; slot
// words are written on define before they are ever used, so the memory needs no clear
// results cannot be held off: each is on the ports for one cycle only
module pausable_timer_bank_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [2:0]  action_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] now_sec_i,
  input  logic [31:0] duration_sec_i,
  input  logic        repeat_on_i,
  input  logic        has_target_i,
  input  logic [1:0]  target_kind_i,
  input  logic [7:0]  target_number_i,
  input  logic        target_start_i,
  output logic        result_valid_o,
  output logic [1:0]  status_code_o,
  output logic [1:0]  result_kind_o,
  output logic [3:0]  slot_o,
  output logic [1:0]  timer_state_o,
  output logic [31:0] remaining_sec_o,
  output logic        fire_target_o,
  output logic [1:0]  fired_kind_o,
  output logic [7:0]  fired_number_o,
  output logic        fired_start_o,
  output logic        persist_needed_o,
  output logic        last_o
);

  // sequencer and control state
  ptb_pkg::fsm_e              state_q, state_d;
  ptb_pkg::addr_t             cnt_q, cnt_d;
  logic                       persist_q, persist_d;
  ptb_pkg::sec_t              floor_q;
  logic [ptb_pkg::SLOTS-1:0]  used_q, used_d;

  // latched command item
  ptb_pkg::action_e action_q;
  ptb_pkg::idx_t    idx_q;
  logic             idx_ok_q;
  ptb_pkg::sec_t    now_q;
  ptb_pkg::sec_t    dur_q;
  logic             rep_q;
  logic             ht_q;
  logic [1:0]       tk_q;
  logic [7:0]       tn_q;
  logic             ts_q;

  // result register
  logic             valid_q, valid_d;
  ptb_pkg::status_e status_q, status_d;
  ptb_pkg::rkind_e  kind_q, kind_d;
  ptb_pkg::idx_t    slot_q, slot_d;
  ptb_pkg::run_e    tstate_q, tstate_d;
  ptb_pkg::sec_t    rem_q, rem_d;
  logic             fire_q, fire_d;
  logic [1:0]       fk_q, fk_d;
  logic [7:0]       fn_q, fn_d;
  logic             fs_q, fs_d;
  logic             pers_q, pers_d;
  logic             last_q, last_d;

  // slot memory
  logic                         ram_we;
  ptb_pkg::addr_t               ram_waddr;
  ptb_pkg::addr_t               ram_raddr;
  logic [ptb_pkg::ENTRY_W-1:0]  ram_rdata;
  ptb_pkg::entry_t              entry_rd;
  ptb_pkg::eval_t               ev;
  ptb_pkg::action_e             ev_action;

  ptb_pkg::action_e act_in;
  logic             accept;
  logic             used_cur;
  logic             used_after;
  ptb_pkg::run_e    run_after;

  assign act_in   = ptb_pkg::action_e'(action_i);
  assign accept   = start && !busy;
  assign busy     = (state_q != ptb_pkg::FSM_IDLE);
  assign entry_rd = ptb_pkg::entry_t'(ram_rdata);

  // the scan reads the next slot while the current one is written back
  assign ram_raddr = (state_q == ptb_pkg::FSM_SCAN) ? ptb_pkg::addr_t'(cnt_q + 1'b1) :
                     (act_in == ptb_pkg::ACT_TICK)  ? '0 : ptb_pkg::addr_t'(timer_index_i);
  assign ram_waddr = (state_q == ptb_pkg::FSM_SCAN) ? cnt_q : ptb_pkg::addr_t'(idx_q);
  assign ev_action = (state_q == ptb_pkg::FSM_SCAN) ? ptb_pkg::ACT_TICK : action_q;
  assign used_cur  = (state_q == ptb_pkg::FSM_SCAN) ? used_q[cnt_q]
                                                     : used_q[ptb_pkg::addr_t'(idx_q)];

  ptb_ram #(
    .WIDTH (ptb_pkg::ENTRY_W),
    .DEPTH (ptb_pkg::SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ev.entry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptb_eval u_eval (
    .action_i        (ev_action),
    .entry_i         (entry_rd),
    .now_i           (now_q),
    .floor_i         (floor_q),
    .duration_i      (dur_q),
    .repeat_i        (rep_q),
    .has_target_i    (ht_q),
    .target_kind_i   (tk_q),
    .target_number_i (tn_q),
    .target_start_i  (ts_q),
    .result_o        (ev)
  );

  // slot state as seen in the reply
  always_comb begin
    used_after = used_cur;
    if (action_q == ptb_pkg::ACT_DEFINE && ev.we) begin
      used_after = 1'b1;
    end else if (action_q == ptb_pkg::ACT_REMOVE) begin
      used_after = 1'b0;
    end
    run_after = used_after ? ev.entry.run : ptb_pkg::RUN_IDLE;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    persist_d = persist_q;
    used_d    = used_q;
    ram_we    = 1'b0;
    valid_d   = 1'b0;
    status_d  = ptb_pkg::STS_OK;
    kind_d    = ptb_pkg::RK_REPLY;
    slot_d    = '0;
    tstate_d  = ptb_pkg::RUN_IDLE;
    rem_d     = '0;
    fire_d    = 1'b0;
    fk_d      = '0;
    fn_d      = '0;
    fs_d      = 1'b0;
    pers_d    = 1'b0;
    last_d    = 1'b0;

    unique case (state_q)
      ptb_pkg::FSM_IDLE: begin
        if (accept) begin
          if (act_in != ptb_pkg::ACT_TICK) begin
            state_d = ptb_pkg::FSM_CMD;
          end else if (now_sec_i > floor_q) begin
            state_d   = ptb_pkg::FSM_SCAN;
            cnt_d     = '0;
            persist_d = 1'b0;
          end else begin
            // early tick: tick end only
            valid_d  = 1'b1;
            status_d = ptb_pkg::STS_BAD_STATE;
            kind_d   = ptb_pkg::RK_TICK_END;
            last_d   = 1'b1;
          end
        end
      end

      ptb_pkg::FSM_CMD: begin
        state_d = ptb_pkg::FSM_IDLE;
        valid_d = 1'b1;
        kind_d  = ptb_pkg::RK_REPLY;
        slot_d  = idx_q;
        last_d  = 1'b1;
        if (!idx_ok_q || (!used_cur && action_q != ptb_pkg::ACT_DEFINE)) begin
          status_d = ptb_pkg::STS_EMPTY;
        end else begin
          ram_we   = ev.we;
          status_d = ev.status;
          rem_d    = ev.remaining;
          tstate_d = run_after;
          used_d[ptb_pkg::addr_t'(idx_q)] = used_after;
        end
      end

      ptb_pkg::FSM_SCAN: begin
        if (used_cur && ev.expired) begin
          ram_we    = 1'b1;
          persist_d = 1'b1;
          valid_d   = 1'b1;
          kind_d    = ptb_pkg::RK_EXPIRY;
          slot_d    = ptb_pkg::idx_t'(cnt_q);
          tstate_d  = ev.entry.run;
          fire_d    = entry_rd.def.has_target;
          fk_d      = entry_rd.def.has_target ? entry_rd.def.kind : 2'b00;
          fn_d      = entry_rd.def.has_target ? entry_rd.def.number : 8'h00;
          fs_d      = entry_rd.def.has_target & entry_rd.def.tstart;
        end
        if (int'(cnt_q) == ptb_pkg::SLOTS - 1) begin
          state_d = ptb_pkg::FSM_END;
        end else begin
          cnt_d = ptb_pkg::addr_t'(cnt_q + 1'b1);
        end
      end

      ptb_pkg::FSM_END: begin
        state_d = ptb_pkg::FSM_IDLE;
        valid_d = 1'b1;
        kind_d  = ptb_pkg::RK_TICK_END;
        pers_d  = persist_q;
        last_d  = 1'b1;
      end

      default: begin
        state_d = ptb_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptb_pkg::FSM_IDLE;
      cnt_q     <= '0;
      persist_q <= 1'b0;
      floor_q   <= ptb_pkg::FLOOR_RESET;
      used_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      persist_q <= persist_d;
      used_q    <= used_d;
      valid_q   <= valid_d;
      if (cfg_we_i) begin
        floor_q <= cfg_wdata_i;
      end
    end
  end

  // item and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= act_in;
      idx_q    <= timer_index_i;
      idx_ok_q <= (int'(timer_index_i) < ptb_pkg::SLOTS);
      now_q    <= now_sec_i;
      dur_q    <= duration_sec_i;
      rep_q    <= repeat_on_i;
      ht_q     <= has_target_i;
      tk_q     <= target_kind_i;
      tn_q     <= target_number_i;
      ts_q     <= target_start_i;
    end
    status_q <= status_d;
    kind_q   <= kind_d;
    slot_q   <= slot_d;
    tstate_q <= tstate_d;
    rem_q    <= rem_d;
    fire_q   <= fire_d;
    fk_q     <= fk_d;
    fn_q     <= fn_d;
    fs_q     <= fs_d;
    pers_q   <= pers_d;
    last_q   <= last_d;
  end

  assign result_valid_o   = valid_q;
  assign status_code_o    = status_q;
  assign result_kind_o    = kind_q;
  assign slot_o           = slot_q;
  assign timer_state_o    = tstate_q;
  assign remaining_sec_o  = rem_q;
  assign fire_target_o    = fire_q;
  assign fired_kind_o     = fk_q;
  assign fired_number_o   = fn_q;
  assign fired_start_o    = fs_q;
  assign persist_needed_o = pers_q;
  assign last_o           = last_q;

endmodule

>>> rtl/core/ptb_ram.sv
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/ptb_eval.sv
module ptb_eval (
  input  ptb_pkg::action_e action_i,
  input  ptb_pkg::entry_t  entry_i,
  input  ptb_pkg::sec_t    now_i,
  input  ptb_pkg::sec_t    floor_i,
  input  ptb_pkg::sec_t    duration_i,
  input  logic             repeat_i,
  input  logic             has_target_i,
  input  logic [1:0]       target_kind_i,
  input  logic [7:0]       target_number_i,
  input  logic             target_start_i,
  output ptb_pkg::eval_t   result_o
);

  ptb_pkg::sec_t elapsed;
  logic          late;
  logic [33:0]   minuend;
  logic [33:0]   subtrahend;
  logic [33:0]   diff;

  // elapsed time as a wrapped difference, sign in bit 31
  assign elapsed = now_i - entry_i.start;
  assign late    = (now_i > floor_i);

  // remaining time for a query, one 34-bit subtract then clamp
  always_comb begin
    minuend    = {2'b00, entry_i.interval};
    subtrahend = '0;
    if (entry_i.run == ptb_pkg::RUN_RUN && late) begin
      subtrahend = {{2{elapsed[31]}}, elapsed};
    end else if (entry_i.run == ptb_pkg::RUN_PAUSE) begin
      subtrahend = {2'b00, entry_i.paused};
    end else if (entry_i.run == ptb_pkg::RUN_DONE) begin
      minuend = '0;
    end
  end

  assign diff = minuend - subtrahend;

  always_comb begin
    result_o           = '0;
    result_o.status    = ptb_pkg::STS_OK;
    result_o.entry     = entry_i;
    unique case (action_i)
      ptb_pkg::ACT_DEFINE: begin
        if (duration_i == '0 || (has_target_i && target_kind_i == ptb_pkg::KIND_INVALID)) begin
          result_o.status = ptb_pkg::STS_BAD_DEF;
        end else begin
          result_o.we                   = 1'b1;
          result_o.entry.run            = ptb_pkg::RUN_IDLE;
          result_o.entry.start          = '0;
          result_o.entry.paused         = '0;
          result_o.entry.interval       = duration_i;
          result_o.entry.def.rep        = repeat_i;
          result_o.entry.def.has_target = has_target_i;
          result_o.entry.def.kind       = has_target_i ? target_kind_i : 2'b00;
          result_o.entry.def.number     = has_target_i ? target_number_i : 8'h00;
          result_o.entry.def.tstart     = has_target_i & target_start_i;
        end
      end
      ptb_pkg::ACT_START: begin
        if (entry_i.run == ptb_pkg::RUN_IDLE || entry_i.run == ptb_pkg::RUN_DONE) begin
          result_o.we           = 1'b1;
          result_o.entry.run    = ptb_pkg::RUN_RUN;
          result_o.entry.start  = now_i;
          result_o.entry.paused = '0;
        end else begin
          result_o.status = ptb_pkg::STS_BAD_STATE;
        end
      end
      ptb_pkg::ACT_PAUSE: begin
        if (entry_i.run == ptb_pkg::RUN_RUN) begin
          result_o.we           = 1'b1;
          result_o.entry.run    = ptb_pkg::RUN_PAUSE;
          result_o.entry.paused = elapsed[31] ? '0 : elapsed;
        end else begin
          result_o.status = ptb_pkg::STS_BAD_STATE;
        end
      end
      ptb_pkg::ACT_RESUME: begin
        if (entry_i.run == ptb_pkg::RUN_PAUSE) begin
          result_o.we          = 1'b1;
          result_o.entry.run   = ptb_pkg::RUN_RUN;
          result_o.entry.start = now_i - entry_i.paused;
        end else begin
          result_o.status = ptb_pkg::STS_BAD_STATE;
        end
      end
      ptb_pkg::ACT_STOP: begin
        if (entry_i.run != ptb_pkg::RUN_IDLE) begin
          result_o.we           = 1'b1;
          result_o.entry.run    = ptb_pkg::RUN_IDLE;
          result_o.entry.start  = '0;
          result_o.entry.paused = '0;
        end else begin
          result_o.status = ptb_pkg::STS_BAD_STATE;
        end
      end
      ptb_pkg::ACT_REMOVE: begin
        // the slot is freed by its used bit, the word is rewritten on define
        result_o.status = ptb_pkg::STS_OK;
      end
      ptb_pkg::ACT_TICK: begin
        if (entry_i.run == ptb_pkg::RUN_RUN && !elapsed[31] && elapsed >= entry_i.interval) begin
          result_o.expired = 1'b1;
          result_o.we      = 1'b1;
          if (entry_i.def.rep) begin
            result_o.entry.start  = entry_i.start + entry_i.interval;
            result_o.entry.paused = '0;
          end else begin
            result_o.entry.run = ptb_pkg::RUN_DONE;
          end
        end
      end
      ptb_pkg::ACT_QUERY: begin
        if (diff[33]) begin
          result_o.remaining = '0;
        end else if (diff[32]) begin
          result_o.remaining = '1;
        end else begin
          result_o.remaining = diff[31:0];
        end
      end
      default: begin
        result_o.status = ptb_pkg::STS_OK;
      end
    endcase
  end

endmodule

>>> sim/pausable_timer_bank_tb.sv
`timescale 1ns / 100ps

module pausable_timer_bank_top_tb;

  // timing of the bench
  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 6;
  // a tick scans every slot and then gives its tick end, so this covers the tail
  localparam int SETTLE_CYCLES = ptb_pkg::TIMERS + 4;
  localparam int TAIL_CYCLES   = 3 * (ptb_pkg::TIMERS + 4);
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;

  // target kinds of a timer definition
  localparam logic [1:0] TGT_ACTUATOR   = 2'd0;
  localparam logic [1:0] TGT_CONTROLLER = 2'd1;
  localparam logic [1:0] TGT_PROGRAM    = 2'd2;

  localparam longint signed SEC_MAX = 64'h0000_0000_FFFF_FFFF;

  // what the driver does with the head of its backlog
  typedef enum logic [1:0] {
    STEP_CMD   = 2'd0,
    STEP_FLOOR = 2'd1,
    STEP_DRAIN = 2'd2
  } step_e;

  typedef struct packed {
    step_e            step;
    ptb_pkg::action_e act;
    logic [3:0]       idx;
    ptb_pkg::sec_t    now;
    ptb_pkg::sec_t    dur;
    ptb_pkg::sec_t    floor;
    logic             rep;
    logic             ht;
    logic [1:0]       tk;
    logic [7:0]       tn;
    logic             ts;
    logic             steady;
  } cmd_t;

  // one result item, in port order
  typedef struct packed {
    ptb_pkg::status_e status;
    ptb_pkg::rkind_e  kind;
    logic [3:0]       slot;
    ptb_pkg::run_e    state;
    ptb_pkg::sec_t    remaining;
    logic             fire;
    logic [1:0]       fkind;
    logic [7:0]       fnum;
    logic             fstart;
    logic             persist;
    logic             last;
  } outcome_t;

  // dut signals, all inputs known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic        cfg_we_i        = 1'b0;
  logic [31:0] cfg_wdata_i     = '0;
  logic [2:0]  action_i        = '0;
  logic [3:0]  timer_index_i   = '0;
  logic [31:0] now_sec_i       = '0;
  logic [31:0] duration_sec_i  = '0;
  logic        repeat_on_i     = 1'b0;
  logic        has_target_i    = 1'b0;
  logic [1:0]  target_kind_i   = '0;
  logic [7:0]  target_number_i = '0;
  logic        target_start_i  = 1'b0;
  logic        result_valid_o;
  logic [1:0]  status_code_o;
  logic [1:0]  result_kind_o;
  logic [3:0]  slot_o;
  logic [1:0]  timer_state_o;
  logic [31:0] remaining_sec_o;
  logic        fire_target_o;
  logic [1:0]  fired_kind_o;
  logic [7:0]  fired_number_o;
  logic        fired_start_o;
  logic        persist_needed_o;
  logic        last_o;

  // pending stimulus and results still owed by the block
  cmd_t     cmd_backlog[$];
  outcome_t replies_due[$];

  // shadow copy of the timer bank
  ptb_pkg::sec_t floor_epoch;
  logic          slot_live  [ptb_pkg::TIMERS];
  ptb_pkg::run_e slot_run   [ptb_pkg::TIMERS];
  ptb_pkg::sec_t slot_begin [ptb_pkg::TIMERS];
  ptb_pkg::sec_t slot_held  [ptb_pkg::TIMERS];
  ptb_pkg::sec_t slot_len   [ptb_pkg::TIMERS];
  ptb_pkg::def_t slot_def   [ptb_pkg::TIMERS];

  ptb_pkg::sec_t sim_now;
  logic taken = 1'b0;
  int   settle_cnt = 0;
  int   mismatches = 0;
  int   cycles = 0;

  pausable_timer_bank_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .timer_index_i    (timer_index_i),
    .now_sec_i        (now_sec_i),
    .duration_sec_i   (duration_sec_i),
    .repeat_on_i      (repeat_on_i),
    .has_target_i     (has_target_i),
    .target_kind_i    (target_kind_i),
    .target_number_i  (target_number_i),
    .target_start_i   (target_start_i),
    .result_valid_o   (result_valid_o),
    .status_code_o    (status_code_o),
    .result_kind_o    (result_kind_o),
    .slot_o           (slot_o),
    .timer_state_o    (timer_state_o),
    .remaining_sec_o  (remaining_sec_o),
    .fire_target_o    (fire_target_o),
    .fired_kind_o     (fired_kind_o),
    .fired_number_o   (fired_number_o),
    .fired_start_o    (fired_start_o),
    .persist_needed_o (persist_needed_o),
    .last_o           (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // wrapped difference read as two's complement
  function automatic longint signed elapsed(input ptb_pkg::sec_t now,
                                            input ptb_pkg::sec_t origin);
    ptb_pkg::sec_t d;
    d = now - origin;
    return {{32{d[31]}}, d};
  endfunction

  function automatic string show(input outcome_t o);
    return $sformatf({"status=%0d kind=%0d slot=%0d state=%0d rem=%0d fire=%0d ",
                      "fkind=%0d fnum=%0d fstart=%0d persist=%0d last=%0d"},
                     o.status, o.kind, o.slot, o.state, o.remaining, o.fire,
                     o.fkind, o.fnum, o.fstart, o.persist, o.last);
  endfunction

  // appends one owed result at the tail
  function automatic void owe_reply(input outcome_t o);
    replies_due.insert(replies_due.size(), o);
  endfunction

  // works out the results of one accepted item and moves the shadow bank on
  function automatic void predict_replies(input ptb_pkg::action_e act,
                                          input logic [3:0] idx,
                                          input ptb_pkg::sec_t now,
                                          input ptb_pkg::sec_t dur,
                                          input ptb_pkg::def_t req);
    outcome_t r, x;
    longint signed left, span;
    r      = '0;
    r.last = 1'b1;
    if (act == ptb_pkg::ACT_TICK) begin
      r.kind = ptb_pkg::RK_TICK_END;
      // too early: nothing is scanned
      if (now <= floor_epoch) begin
        r.status = ptb_pkg::STS_BAD_STATE;
        owe_reply(r);
        return;
      end
      for (int i = 0; i < ptb_pkg::TIMERS; i++) begin
        span = slot_len[i];
        if (slot_live[i] && slot_run[i] == ptb_pkg::RUN_RUN &&
            elapsed(now, slot_begin[i]) >= span) begin
          x        = '0;
          x.kind   = ptb_pkg::RK_EXPIRY;
          x.slot   = 4'(i);
          x.fire   = slot_def[i].has_target;
          x.fkind  = slot_def[i].kind;
          x.fnum   = slot_def[i].number;
          x.fstart = slot_def[i].tstart;
          // repeating timers rebase by one interval only, even when late
          if (slot_def[i].rep) begin
            slot_begin[i] = slot_begin[i] + slot_len[i];
            slot_held[i]  = '0;
          end else begin
            slot_run[i] = ptb_pkg::RUN_DONE;
          end
          x.state   = slot_run[i];
          r.persist = 1'b1;
          owe_reply(x);
        end
      end
      owe_reply(r);
      return;
    end

    r.kind = ptb_pkg::RK_REPLY;
    r.slot = idx;
    if (!slot_live[idx] && act != ptb_pkg::ACT_DEFINE) begin
      r.status = ptb_pkg::STS_EMPTY;
      owe_reply(r);
      return;
    end

    case (act)
      ptb_pkg::ACT_DEFINE: begin
        if (dur == '0 || (req.has_target && req.kind == ptb_pkg::KIND_INVALID)) begin
          r.status = ptb_pkg::STS_BAD_DEF;
        end else begin
          slot_live[idx] = 1'b1;
          slot_len[idx]  = dur;
          slot_def[idx]  = req;
          if (!req.has_target) begin
            slot_def[idx].kind   = '0;
            slot_def[idx].number = '0;
            slot_def[idx].tstart = 1'b0;
          end
          slot_run[idx]   = ptb_pkg::RUN_IDLE;
          slot_begin[idx] = '0;
          slot_held[idx]  = '0;
        end
      end
      ptb_pkg::ACT_START: begin
        if (slot_run[idx] != ptb_pkg::RUN_IDLE && slot_run[idx] != ptb_pkg::RUN_DONE) begin
          r.status = ptb_pkg::STS_BAD_STATE;
        end else begin
          slot_run[idx]   = ptb_pkg::RUN_RUN;
          slot_begin[idx] = now;
          slot_held[idx]  = '0;
        end
      end
      ptb_pkg::ACT_PAUSE: begin
        if (slot_run[idx] != ptb_pkg::RUN_RUN) begin
          r.status = ptb_pkg::STS_BAD_STATE;
        end else begin
          left           = elapsed(now, slot_begin[idx]);
          slot_held[idx] = (left < 0) ? '0 : left[31:0];
          slot_run[idx]  = ptb_pkg::RUN_PAUSE;
        end
      end
      ptb_pkg::ACT_RESUME: begin
        if (slot_run[idx] != ptb_pkg::RUN_PAUSE) begin
          r.status = ptb_pkg::STS_BAD_STATE;
        end else begin
          slot_begin[idx] = now - slot_held[idx];
          slot_run[idx]   = ptb_pkg::RUN_RUN;
        end
      end
      ptb_pkg::ACT_STOP: begin
        if (slot_run[idx] == ptb_pkg::RUN_IDLE) begin
          r.status = ptb_pkg::STS_BAD_STATE;
        end else begin
          slot_run[idx]   = ptb_pkg::RUN_IDLE;
          slot_begin[idx] = '0;
          slot_held[idx]  = '0;
        end
      end
      ptb_pkg::ACT_REMOVE: begin
        slot_live[idx]  = 1'b0;
        slot_run[idx]   = ptb_pkg::RUN_IDLE;
        slot_begin[idx] = '0;
        slot_held[idx]  = '0;
      end
      ptb_pkg::ACT_QUERY: begin
        left = slot_len[idx];
        // a running timer counts down only once the clock is trusted
        if (slot_run[idx] == ptb_pkg::RUN_RUN && now > floor_epoch) begin
          left = left - elapsed(now, slot_begin[idx]);
        end else if (slot_run[idx] == ptb_pkg::RUN_PAUSE) begin
          span = slot_held[idx];
          left = left - span;
        end else if (slot_run[idx] == ptb_pkg::RUN_DONE) begin
          left = 0;
        end
        if (left < 0) left = 0;
        if (left > SEC_MAX) left = SEC_MAX;
        r.remaining = left[31:0];
      end
      default: ;
    endcase
    r.state = slot_live[idx] ? slot_run[idx] : ptb_pkg::RUN_IDLE;
    owe_reply(r);
  endfunction

  function automatic void queue_cmd(input ptb_pkg::action_e a, input logic [3:0] i,
                                    input ptb_pkg::sec_t now, input ptb_pkg::sec_t dur,
                                    input logic rep, input logic ht,
                                    input logic [1:0] tk, input logic [7:0] tn,
                                    input logic ts, input logic steady);
    cmd_t c;
    c.step   = STEP_CMD;
    c.act    = a;
    c.idx    = i;
    c.now    = now;
    c.dur    = dur;
    c.floor  = '0;
    c.rep    = rep;
    c.ht     = ht;
    c.tk     = tk;
    c.tn     = tn;
    c.ts     = ts;
    c.steady = steady;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  // non-define commands carry noise in the definition fields
  function automatic void push_op(input ptb_pkg::action_e a, input logic [3:0] i,
                                  input ptb_pkg::sec_t now, input logic steady);
    queue_cmd(a, i, now, $urandom, 1'($urandom), 1'($urandom), 2'($urandom),
              8'($urandom), 1'($urandom), steady);
  endfunction

  function automatic void push_step(input step_e s, input ptb_pkg::sec_t value);
    cmd_t c;
    c       = '0;
    c.step  = s;
    c.act   = ptb_pkg::ACT_QUERY;
    c.floor = value;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  // mostly small forward steps in time on a handful of slots
  function automatic void push_random(input logic steady);
    int               roll;
    ptb_pkg::action_e a;
    logic [3:0]       i;
    ptb_pkg::sec_t    dur;
    roll = $urandom_range(0, 99);
    if (roll < 70)      sim_now = sim_now + $urandom_range(0, 3);
    else if (roll < 85) sim_now = sim_now + $urandom_range(4, 16);
    else if (roll < 92) sim_now = sim_now - $urandom_range(1, 20);
    else                sim_now = $urandom;
    i = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 25)      a = ptb_pkg::ACT_TICK;
    else if (roll < 40) a = ptb_pkg::ACT_DEFINE;
    else if (roll < 55) a = ptb_pkg::ACT_START;
    else if (roll < 65) a = ptb_pkg::ACT_PAUSE;
    else if (roll < 75) a = ptb_pkg::ACT_RESUME;
    else if (roll < 82) a = ptb_pkg::ACT_STOP;
    else if (roll < 87) a = ptb_pkg::ACT_REMOVE;
    else                a = ptb_pkg::ACT_QUERY;
    if (a == ptb_pkg::ACT_DEFINE) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      dur = $urandom_range(1, 8);
      else if (roll < 80) dur = '0;
      else if (roll < 90) dur = $urandom;
      else                dur = '1;
      queue_cmd(a, i, sim_now, dur, 1'($urandom), 1'($urandom), 2'($urandom_range(0, 3)),
                8'($urandom), 1'($urandom), steady);
    end else begin
      push_op(a, i, sim_now, steady);
    end
  endfunction

  // sender: items change on the falling edge, held until accepted
  always @(negedge clk_i) begin : drive_items
    cmd_t head;
    logic go, we;
    go = 1'b0;
    we = 1'b0;
    if (rst_ni) begin
      if (start && !taken) begin
        // item not yet taken, keep it up
        go = 1'b1;
      end else if (cmd_backlog.size() != 0) begin
        head = cmd_backlog[0];
        if (head.step == STEP_CMD) begin
          settle_cnt = 0;
          // random gaps, none inside a steady stretch
          if (head.steady || $urandom_range(0, 99) >= 35) begin
            go = 1'b1;
            void'(cmd_backlog.pop_front());
            action_i        <= head.act;
            timer_index_i   <= head.idx;
            now_sec_i       <= head.now;
            duration_sec_i  <= head.dur;
            repeat_on_i     <= head.rep;
            has_target_i    <= head.ht;
            target_kind_i   <= head.tk;
            target_number_i <= head.tn;
            target_start_i  <= head.ts;
          end
        end else if (replies_due.size() != 0 || busy) begin
          // floor writes and drain points wait for a quiet block
          settle_cnt = 0;
        end else if (settle_cnt < SETTLE_CYCLES) begin
          settle_cnt++;
        end else begin
          settle_cnt = 0;
          we = (head.step == STEP_FLOOR);
          cfg_wdata_i <= head.floor;
          void'(cmd_backlog.pop_front());
        end
      end
    end
    start    <= go;
    cfg_we_i <= we;
  end

  // receiver: results sampled on the rising edge, predictions made on acceptance
  always @(posedge clk_i) begin : watch_results
    outcome_t got, want;
    if (!rst_ni) begin
      taken <= 1'b0;
    end else begin
      if (result_valid_o) begin
        got = {status_code_o, result_kind_o, slot_o, timer_state_o, remaining_sec_o,
               fire_target_o, fired_kind_o, fired_number_o, fired_start_o,
               persist_needed_o, last_o};
        if (replies_due.size() == 0) begin
          if (mismatches < REPORT_MAX) $display("result with nothing owed: %s", show(got));
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_MAX) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) floor_epoch = cfg_wdata_i;
      if (start && !busy) begin
        predict_replies(ptb_pkg::action_e'(action_i), timer_index_i, now_sec_i,
                        duration_sec_i,
                        {target_start_i, target_number_i, target_kind_i, has_target_i,
                         repeat_on_i});
      end
      taken <= start && !busy;
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run_test
    ptb_pkg::sec_t t0;
    ptb_pkg::sec_t fl;
    // shadow bank after reset
    floor_epoch = ptb_pkg::FLOOR_RESET;
    for (int i = 0; i < ptb_pkg::TIMERS; i++) begin
      slot_live[i]  = 1'b0;
      slot_run[i]   = ptb_pkg::RUN_IDLE;
      slot_begin[i] = '0;
      slot_held[i]  = '0;
      slot_len[i]   = '0;
      slot_def[i]   = '0;
    end

    // directed part at the reset floor
    t0 = ptb_pkg::FLOOR_RESET + 32'd1000;
    push_op(ptb_pkg::ACT_QUERY, 4'd0, t0, 1'b0);                     // empty slot
    push_op(ptb_pkg::ACT_START, 4'd3, t0, 1'b0);
    queue_cmd(ptb_pkg::ACT_DEFINE, 4'd0, t0, 32'd0, 1'b1, 1'b1, TGT_PROGRAM, 8'hFF, 1'b1,
              1'b0);
    queue_cmd(ptb_pkg::ACT_DEFINE, 4'd1, t0, 32'd7, 1'b0, 1'b1, ptb_pkg::KIND_INVALID, 8'h00,
              1'b0, 1'b0);
    queue_cmd(ptb_pkg::ACT_DEFINE, 4'd0, t0, 32'd5, 1'b1, 1'b1, TGT_PROGRAM, 8'hFF, 1'b1,
              1'b0);
    // no target: the kind field is ignored, even the invalid one
    queue_cmd(ptb_pkg::ACT_DEFINE, 4'd15, t0, 32'hFFFF_FFFF, 1'b0, 1'b0,
              ptb_pkg::KIND_INVALID, 8'hAA, 1'b1, 1'b0);
    push_op(ptb_pkg::ACT_PAUSE, 4'd0, t0, 1'b0);                     // wrong state on idle
    push_op(ptb_pkg::ACT_RESUME, 4'd0, t0, 1'b0);
    push_op(ptb_pkg::ACT_STOP, 4'd0, t0, 1'b0);
    push_op(ptb_pkg::ACT_START, 4'd0, t0, 1'b0);
    push_op(ptb_pkg::ACT_START, 4'd0, t0 + 32'd1, 1'b0);             // already running
    push_op(ptb_pkg::ACT_QUERY, 4'd0, t0 + 32'd2, 1'b0);
    push_op(ptb_pkg::ACT_TICK, 4'd0, ptb_pkg::FLOOR_RESET, 1'b0);    // early tick
    push_op(ptb_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0);
    // untrusted clock, full interval
    push_op(ptb_pkg::ACT_QUERY, 4'd0, ptb_pkg::FLOOR_RESET, 1'b0);
    push_op(ptb_pkg::ACT_TICK, 4'd0, t0 + 32'd5, 1'b0);              // repeating expiry
    push_op(ptb_pkg::ACT_TICK, 4'd0, t0 + 32'd17, 1'b0);             // late, fires once only
    push_op(ptb_pkg::ACT_PAUSE, 4'd0, t0 + 32'd5, 1'b0);             // before its start
    push_op(ptb_pkg::ACT_QUERY, 4'd0, t0 + 32'd6, 1'b0);
    push_op(ptb_pkg::ACT_RESUME, 4'd0, t0 + 32'd20, 1'b0);
    queue_cmd(ptb_pkg::ACT_DEFINE, 4'd2, t0 + 32'd20, 32'd1, 1'b0, 1'b1, TGT_ACTUATOR, 8'h5A,
              1'b0, 1'b0);
    push_op(ptb_pkg::ACT_START, 4'd2, t0 + 32'd30, 1'b0);
    push_op(ptb_pkg::ACT_START, 4'd15, t0 + 32'd30, 1'b0);
    push_op(ptb_pkg::ACT_TICK, 4'd0, t0 + 32'd31, 1'b0);             // one-shot goes done
    push_op(ptb_pkg::ACT_QUERY, 4'd2, t0 + 32'd31, 1'b0);
    push_op(ptb_pkg::ACT_STOP, 4'd2, t0 + 32'd32, 1'b0);
    push_op(ptb_pkg::ACT_STOP, 4'd15, t0 + 32'd32, 1'b0);
    push_op(ptb_pkg::ACT_REMOVE, 4'd2, t0 + 32'd33, 1'b0);
    push_op(ptb_pkg::ACT_QUERY, 4'd2, t0 + 32'd33, 1'b0);
    // redefine a running slot
    queue_cmd(ptb_pkg::ACT_DEFINE, 4'd0, t0 + 32'd34, 32'd3, 1'b0, 1'b1, TGT_CONTROLLER,
              8'h01, 1'b1, 1'b0);
    push_op(ptb_pkg::ACT_QUERY, 4'd15, 32'hFFFF_FFFF, 1'b0);

    // floor at zero, time wraps through zero
    push_step(STEP_FLOOR, 32'd0);
    sim_now = 32'hFFFF_FFC0;
    repeat (70) push_random(1'b0);

    // random floor, time starting just under it
    fl = $urandom;
    push_step(STEP_FLOOR, fl);
    sim_now = fl - 32'd6;
    repeat (70) push_random(1'b0);

    // highest floor: every tick is early
    push_step(STEP_FLOOR, 32'hFFFF_FFFF);
    repeat (20) push_random(1'b0);

    // back to the reset floor, with a gap-free stretch and a full drain
    push_step(STEP_FLOOR, ptb_pkg::FLOOR_RESET);
    sim_now = ptb_pkg::FLOOR_RESET + 32'd50;
    for (int lap = 0; lap < 90; lap++) begin
      if (lap == 45) push_step(STEP_DRAIN, '0);
      push_random(lap >= 10 && lap < 40);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start || replies_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ptb_pkg.sv
rtl/core/ptb_ram.sv
rtl/core/ptb_eval.sv
rtl/core/pausable_timer_bank_top.sv
sim/pausable_timer_bank_tb.sv
